### rtl/core/bitmap_slot_allocator_assert.svh
// Assertion macros for the slot allocator.
`ifndef BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BSA_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define BSA_ASSERT_IMP(label, clk, rst_n, a, c)
`define BSA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/core/bsa_pkg.sv
package bsa_pkg;
    localparam int SLOTS_LOG2_DEF = 10;
    localparam int WORD_LOG2_DEF  = 5;
    localparam int POOL_COUNT_DEF = 8;
    localparam int HANDLE_W       = 13;
    localparam int STATUS_W       = 3;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_COLLECT = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_MEM    = 3'd1,
        ST_DBL_FREE  = 3'd2,
        ST_NO_POOL   = 3'd3,
        ST_NO_EMPTY  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_APOOL,
        S_AREAD,
        S_AWAIT,
        S_ACHK,
        S_ANEW,
        S_FREAD,
        S_FWAIT,
        S_CPOOL,
        S_CWIPE,
        S_OUT
    } t_state;
endpackage

### rtl/core/bsa_ram.sv
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/core/bsa_lsb.sv
module bsa_lsb #(
    parameter int WORD_LOG2 = 5
) (
    input  logic [(1<<WORD_LOG2)-1:0] i_word,
    output logic [WORD_LOG2-1:0]      o_idx
);
    localparam int WB = 1 << WORD_LOG2;
    always_comb begin
        o_idx = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (i_word[b]) begin
                o_idx = b[WORD_LOG2-1:0];
            end
        end
    end
endmodule

### rtl/core/bitmap_slot_allocator.sv
// channel | dir | tdata bits (low first)              | tuser
// s_axis  | in  | handle[12:0], pad to 16             | opcode[1:0]
// m_axis  | out | handle_out[12:0], pad to 16         | status[2:0]
// After reset a clearing pass writes all-ones to each bitmap word, one word a cycle
// (POOL_COUNT * 2^(SLOTS_LOG2-WORD_LOG2) words, 256 by default); no word is accepted then.
// Allocate scans the pools from the hint pool, skipping inactive and empty pools, and reads
// from that pool's word hint, skipping full words; if no pool from the hint on has room, it
// activates the first inactive pool. Free reads the word and sets the bit (ST_NO_POOL for an unknown pool).
// Collect visits every pool and rewrites to all ones each bitmap word of each emptied pool.
// One word at a time; the bitmap RAM port sets the pace. A held result blocks the next word.
`include "bitmap_slot_allocator_assert.svh"
module bitmap_slot_allocator #(
    parameter int SLOTS_LOG2 = bsa_pkg::SLOTS_LOG2_DEF,
    parameter int WORD_LOG2  = bsa_pkg::WORD_LOG2_DEF,
    parameter int POOL_COUNT = bsa_pkg::POOL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // handle[12:0]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // handle_out[12:0]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);
    import bsa_pkg::*;

    localparam int WB    = 1 << WORD_LOG2;
    localparam int WPP_L = SLOTS_LOG2 - WORD_LOG2;
    localparam int WPP   = 1 << WPP_L;
    localparam int PW    = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int PH    = $clog2(POOL_COUNT + 1);
    localparam int AW    = PW + WPP_L;
    localparam int DEPTH = POOL_COUNT * WPP;
    localparam int RAW   = $clog2(DEPTH);
    localparam int FCW   = SLOTS_LOG2 + 1;
    localparam int WHW   = WPP_L + 1;
    localparam int HPW   = HANDLE_W - SLOTS_LOG2 > 0 ? HANDLE_W - SLOTS_LOG2 : 1;
    localparam logic [FCW-1:0] FULL = FCW'(1) << SLOTS_LOG2;

    t_state r_state, n_state;
    logic [FCW-1:0] r_fc [POOL_COUNT];
    logic [WHW-1:0] r_wh [POOL_COUNT];
    logic [POOL_COUNT-1:0] r_act;
    logic [PH-1:0] r_ph, n_ph;
    logic [PH-1:0] r_p, n_p;
    logic [WHW-1:0] r_w, n_w;
    logic [RAW-1:0] r_clr, n_clr;
    logic [HANDLE_W-1:0] r_hin, n_hin;
    logic [HANDLE_W-1:0] r_hout, n_hout;
    logic [STATUS_W-1:0] r_st, n_st;
    logic r_any, n_any, r_kept_all, n_kept_all;

    logic we;
    logic [RAW-1:0] waddr, raddr;
    logic [WB-1:0] wdata, rdata;
    logic [WORD_LOG2-1:0] bit_idx;

    logic fc_we; logic [PW-1:0] fc_p; logic [FCW-1:0] fc_d;
    logic wh_we; logic [WHW-1:0] wh_d;
    logic act_we, act_d;

    logic [PW-1:0] pi, fpi;
    logic [WPP_L-1:0] fw;
    logic [WORD_LOG2-1:0] fb;
    logic [HPW-1:0] fpool;
    logic [WB-1:0] fmask, cleared;

    bsa_ram #(.WIDTH(WB), .DEPTH(DEPTH)) u_bitmap (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
    bsa_lsb #(.WORD_LOG2(WORD_LOG2)) u_lsb (.i_word(rdata), .o_idx(bit_idx));

    assign pi    = r_p[PW-1:0];
    assign fpool = HPW'(r_hin >> SLOTS_LOG2);
    assign fpi   = PW'(fpool);
    assign fw    = WPP_L'(r_hin >> WORD_LOG2);
    assign fb    = r_hin[WORD_LOG2-1:0];
    assign fmask = WB'(1) << fb;
    assign cleared = rdata & ~(WB'(1) << bit_idx);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {{(16-HANDLE_W){1'b0}}, r_hout};
    assign m_axis_tuser  = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_act <= '0;
            r_ph <= '0;
            r_clr <= '0;
            for (int i = 0; i < POOL_COUNT; i++) begin
                r_fc[i] <= '0;
                r_wh[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ph <= n_ph;
            r_clr <= n_clr;
            if (fc_we) r_fc[fc_p] <= fc_d;
            if (wh_we) r_wh[fc_p] <= wh_d;
            if (act_we) r_act[fc_p] <= act_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p; r_w <= n_w; r_hin <= n_hin;
        r_hout <= n_hout; r_st <= n_st; r_any <= n_any; r_kept_all <= n_kept_all;
    end

    always_comb begin
        n_state = r_state; n_ph = r_ph; n_p = r_p; n_w = r_w; n_clr = r_clr;
        n_hin = r_hin; n_hout = r_hout; n_st = r_st;
        n_any = r_any; n_kept_all = r_kept_all;
        we = 1'b0; waddr = '0; wdata = '1; raddr = '0;
        fc_we = 1'b0; fc_p = pi; fc_d = '0; wh_we = 1'b0; wh_d = '0;
        act_we = 1'b0; act_d = 1'b0;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1; waddr = r_clr;
                n_clr = r_clr + RAW'(1);
                if (r_clr == RAW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_hin = s_axis_tdata[HANDLE_W-1:0];
                    n_hout = '0; n_st = ST_OK;
                    n_any = 1'b0; n_kept_all = 1'b1; n_p = '0;
                    case (t_opcode'(s_axis_tuser))
                        OP_ALLOC:   begin n_p = r_ph; n_state = S_APOOL; end
                        OP_FREE:    n_state = S_FREAD;
                        OP_COLLECT: n_state = S_CPOOL;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_APOOL: begin
                if (r_p >= PH'(POOL_COUNT)) begin
                    n_p = '0; n_state = S_ANEW;
                end else if (r_act[pi] && r_fc[pi] != '0) begin
                    n_ph = r_p; n_w = r_wh[pi]; n_state = S_AREAD;
                end else begin
                    n_p = r_p + PH'(1);
                end
            end
            S_AREAD: begin
                if (r_w >= WHW'(WPP)) begin
                    n_st = ST_NO_MEM; n_state = S_OUT;
                end else begin
                    raddr = RAW'({pi, r_w[WPP_L-1:0]});
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (rdata == '0) begin
                    n_w = r_w + WHW'(1); n_state = S_AREAD;
                end else begin
                    we = 1'b1; waddr = RAW'({pi, r_w[WPP_L-1:0]}); wdata = cleared;
                    fc_we = 1'b1; fc_d = r_fc[pi] - FCW'(1);
                    wh_we = 1'b1;
                    wh_d = (cleared == '0) ? r_w + WHW'(1) : r_w;
                    if (r_fc[pi] == FCW'(1)) n_ph = r_ph + PH'(1);
                    n_hout = HANDLE_W'({pi, r_w[WPP_L-1:0], bit_idx});
                    n_state = S_OUT;
                end
            end
            S_ANEW: begin
                if (r_p >= PH'(POOL_COUNT)) begin
                    n_st = ST_NO_MEM; n_state = S_OUT;
                end else if (!r_act[pi]) begin
                    // inactive pool bitmap is already all ones
                    we = 1'b1; waddr = RAW'({pi, {WPP_L{1'b0}}}); wdata = ~WB'(1);
                    fc_we = 1'b1; fc_d = FCW'(FULL - FCW'(1));
                    wh_we = 1'b1; wh_d = '0;
                    act_we = 1'b1; act_d = 1'b1;
                    if (r_ph > r_p) n_ph = r_p;
                    n_hout = HANDLE_W'(AW'(pi) << WPP_L) << WORD_LOG2;
                    n_state = S_OUT;
                end else begin
                    n_p = r_p + PH'(1);
                end
            end
            S_FREAD: begin
                if (int'(fpool) >= POOL_COUNT || !r_act[fpi]) begin
                    n_st = ST_NO_POOL; n_state = S_OUT;
                end else begin
                    raddr = RAW'({fpi, fw});
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: begin
                fc_p = fpi;
                if ((rdata & fmask) != '0) begin
                    n_st = ST_DBL_FREE;
                end else begin
                    we = 1'b1; waddr = RAW'({fpi, fw}); wdata = rdata | fmask;
                    fc_we = 1'b1; fc_d = r_fc[fpi] + FCW'(1);
                    wh_we = 1'b1;
                    wh_d = (r_wh[fpi] > WHW'(fw)) ? WHW'(fw) : r_wh[fpi];
                    if (r_ph > PH'(fpi)) n_ph = PH'(fpi);
                end
                n_state = S_OUT;
            end
            S_CPOOL: begin
                if (r_p >= PH'(POOL_COUNT)) begin
                    n_st = (r_any && r_kept_all) ? ST_NO_EMPTY : ST_OK;
                    n_state = S_OUT;
                end else if (r_act[pi]) begin
                    n_any = 1'b1;
                    if (r_fc[pi] == FULL) begin
                        n_kept_all = 1'b0;
                        act_we = 1'b1; act_d = 1'b0;
                        fc_we = 1'b1; fc_d = '0; wh_we = 1'b1; wh_d = '0;
                        n_w = '0; n_state = S_CWIPE;
                    end else begin
                        n_p = r_p + PH'(1);
                    end
                end else begin
                    n_p = r_p + PH'(1);
                end
            end
            S_CWIPE: begin
                we = 1'b1; waddr = RAW'({pi, r_w[WPP_L-1:0]});
                n_w = r_w + WHW'(1);
                if (r_w == WHW'(WPP - 1)) begin
                    n_p = r_p + PH'(1); n_state = S_CPOOL;
                end
            end
            S_OUT: begin
                if (m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `BSA_ASSERT_IMP(a_rdy_idle, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `BSA_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tuser))
    `BSA_ASSERT_IMP(a_hint, i_clk, i_rst_n, 1'b1, r_ph <= PH'(POOL_COUNT))
endmodule
